// ----- rtl/cabf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cabf_pkg
// Operation codes and flag layout shared by the 8-bit alu and its checker.
// ----------------------------------------------------------------------------
package cabf_pkg;

  localparam int unsigned CMD_W   = 5;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned BIDX_W  = 3;
  localparam int unsigned FLAG_W  = 4;

  // flag bit positions
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD       = 5'd0,
    CMD_ADC       = 5'd1,
    CMD_SUB       = 5'd2,
    CMD_SBC       = 5'd3,
    CMD_AND       = 5'd4,
    CMD_XOR       = 5'd5,
    CMD_OR        = 5'd6,
    CMD_CP        = 5'd7,
    CMD_INC       = 5'd8,
    CMD_DEC       = 5'd9,
    CMD_RLA       = 5'd10,
    CMD_RLCA      = 5'd11,
    CMD_RRA       = 5'd12,
    CMD_RRCA      = 5'd13,
    CMD_DAA       = 5'd14,
    CMD_CPL       = 5'd15,
    CMD_SCF       = 5'd16,
    CMD_CCF       = 5'd17,
    CMD_BIT       = 5'd18,
    CMD_ADD16     = 5'd19,
    CMD_SP_OFFSET = 5'd20
  } cmd_t;

  typedef logic [FLAG_W-1:0] flags_t;

  localparam logic [BYTE_W-1:0] DAA_LOW_ADJ  = 8'h06;
  localparam logic [BYTE_W-1:0] DAA_HIGH_ADJ = 8'h60;
  localparam logic [BYTE_W-1:0] DAA_LIMIT    = 8'h99;
  localparam logic [3:0]        NIBBLE_LIMIT = 4'h9;

  function automatic flags_t mkflags(input logic z, input logic n, input logic h,
                                     input logic c);
    flags_t f;
    f = '0;
    f[FLAG_Z] = z;
    f[FLAG_N] = n;
    f[FLAG_H] = h;
    f[FLAG_C] = c;
    return f;
  endfunction

endpackage

// ----- rtl/cpu_alu_with_bcd_flags.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_alu_with_bcd_flags
// 8-bit cpu alu with decimal adjust, 16-bit add and sp offset add.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_ready  command first_operand second_operand
//                                            bit_index flags_in
//   out      source     out_valid/out_ready  result flags_out
//
// one item per cycle sustained while out is not stalled; each item passes the input
// register, then the result register after one pass of the alu logic.
// rst is synchronous and clears both valid bits only.
// a stalled output holds its item while the input register still takes one
// more; in_ready drops only when both registers are full and out is stalled.
// ----------------------------------------------------------------------------
module cpu_alu_with_bcd_flags (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cabf_pkg::CMD_W-1:0]    command,
  input  logic [cabf_pkg::WORD_W-1:0]   first_operand,
  input  logic [cabf_pkg::WORD_W-1:0]   second_operand,
  input  logic [cabf_pkg::BIDX_W-1:0]   bit_index,
  input  logic [cabf_pkg::FLAG_W-1:0]   flags_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cabf_pkg::WORD_W-1:0]   result,
  output logic [cabf_pkg::FLAG_W-1:0]   flags_out
);
  import cabf_pkg::*;

  logic                s1_valid;
  logic [CMD_W-1:0]    s1_cmd;
  logic [WORD_W-1:0]   s1_op1;
  logic [WORD_W-1:0]   s1_op2;
  logic [BIDX_W-1:0]   s1_bidx;
  flags_t              s1_flags;

  logic                out_adv;
  logic [WORD_W-1:0]   result_next;
  flags_t              flags_out_next;

  assign out_adv  = !out_valid || out_ready;
  assign in_ready = !s1_valid || out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready) begin
      s1_cmd   <= command;
      s1_op1   <= first_operand;
      s1_op2   <= second_operand;
      s1_bidx  <= bit_index;
      s1_flags <= flags_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s1_valid;
    end
    if (out_adv) begin
      result    <= result_next;
      flags_out <= flags_out_next;
    end
  end

  logic [BYTE_W-1:0] a;
  logic [BYTE_W-1:0] b;
  logic              zi, ni, hi, ci, t;
  logic [BYTE_W:0]   sum9;
  logic [4:0]        hsum;
  logic [BYTE_W:0]   diff9;
  logic [4:0]        hdiff;
  logic [BYTE_W-1:0] adj;
  logic [BYTE_W-1:0] daa_res;
  logic              daa_c;
  logic [WORD_W:0]   sum17;
  logic [12:0]       hsum16;
  logic [WORD_W-1:0] sp_sum;
  logic [4:0]        sp_h;
  logic [BYTE_W:0]   sp_c;
  logic [BYTE_W-1:0] r8;

  always_comb begin
    a  = s1_op1[BYTE_W-1:0];
    b  = s1_op2[BYTE_W-1:0];
    zi = s1_flags[FLAG_Z];
    ni = s1_flags[FLAG_N];
    hi = s1_flags[FLAG_H];
    ci = s1_flags[FLAG_C];
    t  = ci && (s1_cmd == CMD_ADC || s1_cmd == CMD_SBC);

    sum9  = {1'b0, a} + {1'b0, b} + {{BYTE_W{1'b0}}, t};
    hsum  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, t};
    diff9 = {1'b0, a} - {1'b0, b} - {{BYTE_W{1'b0}}, t};
    hdiff = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, t};

    adj   = '0;
    daa_c = ci;
    if (ni) begin
      if (hi) adj = adj | DAA_LOW_ADJ;
      if (ci) adj = adj | DAA_HIGH_ADJ;
      daa_res = a - adj;
    end else begin
      if (hi || a[3:0] > NIBBLE_LIMIT) adj = adj | DAA_LOW_ADJ;
      if (ci || a > DAA_LIMIT) begin
        adj   = adj | DAA_HIGH_ADJ;
        daa_c = 1'b1;
      end
      daa_res = a + adj;
    end

    sum17  = {1'b0, s1_op1} + {1'b0, s1_op2};
    hsum16 = {1'b0, s1_op1[11:0]} + {1'b0, s1_op2[11:0]};
    sp_sum = s1_op1 + {{(WORD_W-BYTE_W){b[BYTE_W-1]}}, b};
    sp_h   = {1'b0, s1_op1[3:0]} + {1'b0, b[3:0]};
    sp_c   = {1'b0, s1_op1[BYTE_W-1:0]} + {1'b0, b};

    r8             = a;
    result_next    = s1_op1;
    flags_out_next = s1_flags;

    case (s1_cmd)
      CMD_ADD, CMD_ADC: begin
        r8             = sum9[BYTE_W-1:0];
        flags_out_next = mkflags(r8 == '0, 1'b0, hsum[4], sum9[BYTE_W]);
      end
      CMD_SUB, CMD_SBC: begin
        r8             = diff9[BYTE_W-1:0];
        flags_out_next = mkflags(r8 == '0, 1'b1, hdiff[4], diff9[BYTE_W]);
      end
      CMD_CP: begin
        flags_out_next = mkflags(diff9[BYTE_W-1:0] == '0, 1'b1, hdiff[4], diff9[BYTE_W]);
      end
      CMD_AND: begin
        r8             = a & b;
        flags_out_next = mkflags(r8 == '0, 1'b0, 1'b1, 1'b0);
      end
      CMD_XOR: begin
        r8             = a ^ b;
        flags_out_next = mkflags(r8 == '0, 1'b0, 1'b0, 1'b0);
      end
      CMD_OR: begin
        r8             = a | b;
        flags_out_next = mkflags(r8 == '0, 1'b0, 1'b0, 1'b0);
      end
      CMD_INC: begin
        r8             = a + 8'd1;
        flags_out_next = mkflags(r8 == '0, 1'b0, a[3:0] == 4'hF, ci);
      end
      CMD_DEC: begin
        r8             = a - 8'd1;
        flags_out_next = mkflags(r8 == '0, 1'b1, a[3:0] == 4'h0, ci);
      end
      CMD_RLA: begin
        r8             = {a[BYTE_W-2:0], ci};
        flags_out_next = mkflags(1'b0, 1'b0, 1'b0, a[BYTE_W-1]);
      end
      CMD_RLCA: begin
        r8             = {a[BYTE_W-2:0], a[BYTE_W-1]};
        flags_out_next = mkflags(1'b0, 1'b0, 1'b0, a[BYTE_W-1]);
      end
      CMD_RRA: begin
        r8             = {ci, a[BYTE_W-1:1]};
        flags_out_next = mkflags(1'b0, 1'b0, 1'b0, a[0]);
      end
      CMD_RRCA: begin
        r8             = {a[0], a[BYTE_W-1:1]};
        flags_out_next = mkflags(1'b0, 1'b0, 1'b0, a[0]);
      end
      CMD_DAA: begin
        r8             = daa_res;
        flags_out_next = mkflags(daa_res == '0, ni, 1'b0, daa_c);
      end
      CMD_CPL: begin
        r8             = ~a;
        flags_out_next = mkflags(zi, 1'b1, 1'b1, ci);
      end
      CMD_SCF: begin
        flags_out_next = mkflags(zi, 1'b0, 1'b0, 1'b1);
      end
      CMD_CCF: begin
        flags_out_next = mkflags(zi, 1'b0, 1'b0, !ci);
      end
      CMD_BIT: begin
        flags_out_next = mkflags(!a[s1_bidx], 1'b0, 1'b1, ci);
      end
      default: begin
      end
    endcase

    case (s1_cmd)
      CMD_ADD16: begin
        result_next    = sum17[WORD_W-1:0];
        flags_out_next = mkflags(zi, 1'b0, hsum16[12], sum17[WORD_W]);
      end
      CMD_SP_OFFSET: begin
        result_next    = sp_sum;
        flags_out_next = mkflags(1'b0, 1'b0, sp_h[4], sp_c[BYTE_W]);
      end
      default: begin
        if (s1_cmd <= CMD_BIT) begin
          result_next = {{(WORD_W-BYTE_W){1'b0}}, r8};
        end
      end
    endcase
  end

endmodule

// ----- rtl/cabf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cabf_checker
// Port-level checks on the alu's flow control, bound to the top level.
// ----------------------------------------------------------------------------
module cabf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [cabf_pkg::WORD_W-1:0] result,
  input logic [cabf_pkg::FLAG_W-1:0] flags_out
);
  import cabf_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result) && $stable(flags_out))
    else $error("stalled result changed");

  // input only blocks behind a stalled output
  a_block_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input blocked without output stall");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("valid not cleared by reset");

endmodule

bind cpu_alu_with_bcd_flags cabf_checker u_cabf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .result    (result),
  .flags_out (flags_out)
);
